FILE: rtl/bhc_pkg.sv
// Shared types and constants for the Hall commutation block.
// Used by bhc_duty_scale, bhc_hall_decode and bldc_hall_commutation.
package bhc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned CLAMP_W  = 15;
  localparam int unsigned MAG_W    = 14;
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned OFFS_W   = 11;
  localparam int unsigned HALL_W   = 3;
  localparam int unsigned POS_W    = 32;

  localparam logic [LEVEL_W-1:0] CENTER_LEVEL = 12'h800;
  localparam int                 DUTY_LIMIT   = 10000;

  // floor(x*2047/10000) == (x*RECIP_MULT) >> RECIP_SHIFT for 0 <= x <= 10000
  localparam int unsigned        RECIP_SHIFT  = 27;
  localparam int unsigned        RECIP_W      = 25;
  localparam logic [RECIP_W-1:0] RECIP_MULT   = 25'd27474369;

  typedef enum logic [1:0] {
    DRIVE_CENTER = 2'd0,
    DRIVE_HIGH   = 2'd1,
    DRIVE_LOW    = 2'd2
  } drive_e;

  typedef enum logic [HALL_W-1:0] {
    HALL_BAD_LO = 3'd0,
    HALL_1      = 3'd1,
    HALL_2      = 3'd2,
    HALL_3      = 3'd3,
    HALL_4      = 3'd4,
    HALL_5      = 3'd5,
    HALL_6      = 3'd6,
    HALL_BAD_HI = 3'd7
  } hall_e;

  typedef struct packed {
    drive_e drive_a;
    drive_e drive_b;
    drive_e drive_c;
    logic   fault;
    logic   step_up;
    logic   step_dn;
  } hall_dec_t;

endpackage

FILE: rtl/bhc_duty_scale.sv
// Duty clamp and scaling to high and low PWM compare levels.
// Depends on bhc_pkg.
module bhc_duty_scale (
  input  logic signed [bhc_pkg::DUTY_W-1:0]  duty_i,
  output logic signed [bhc_pkg::CLAMP_W-1:0] duty_clamped_o,
  output logic        [bhc_pkg::LEVEL_W-1:0] level_hi_o,
  output logic        [bhc_pkg::LEVEL_W-1:0] level_lo_o
);
  import bhc_pkg::*;

  localparam logic signed [DUTY_W-1:0] LimPos = DUTY_W'(DUTY_LIMIT);
  localparam logic signed [DUTY_W-1:0] LimNeg = -DUTY_W'(DUTY_LIMIT);
  localparam int unsigned              ProdW  = MAG_W + RECIP_W;

  logic signed [DUTY_W-1:0]  clamped;
  logic                      neg;
  logic        [MAG_W-1:0]   mag;
  logic        [ProdW-1:0]   prod;
  logic        [OFFS_W-1:0]  off_mag;
  logic        [LEVEL_W-1:0] off_ext;

  always_comb begin
    if (duty_i > LimPos) begin
      clamped = LimPos;
    end else if (duty_i < LimNeg) begin
      clamped = LimNeg;
    end else begin
      clamped = duty_i;
    end
  end

  assign neg  = clamped[DUTY_W-1];
  assign mag  = neg ? MAG_W'(-clamped) : MAG_W'(clamped);
  // reciprocal multiply, exact over the clamped range; truncates toward zero
  assign prod = ProdW'(mag) * ProdW'(RECIP_MULT);
  assign off_mag = prod[RECIP_SHIFT +: OFFS_W];
  assign off_ext = {1'b0, off_mag};

  assign duty_clamped_o = CLAMP_W'(clamped);
  assign level_hi_o = neg ? CENTER_LEVEL - off_ext : CENTER_LEVEL + off_ext;
  assign level_lo_o = neg ? CENTER_LEVEL + off_ext : CENTER_LEVEL - off_ext;

endmodule

FILE: rtl/bhc_hall_decode.sv
// Hall code decode: phase drive pattern, fault and step direction.
// Depends on bhc_pkg.
module bhc_hall_decode (
  input  logic [bhc_pkg::HALL_W-1:0] hall_i,
  input  logic [bhc_pkg::HALL_W-1:0] prev_hall_i,
  output bhc_pkg::hall_dec_t         dec_o
);
  import bhc_pkg::*;

  hall_e up_from;
  hall_e dn_from;

  always_comb begin
    dec_o.drive_a = DRIVE_CENTER;
    dec_o.drive_b = DRIVE_CENTER;
    dec_o.drive_c = DRIVE_CENTER;
    dec_o.fault   = 1'b0;
    up_from       = HALL_BAD_LO;
    dn_from       = HALL_BAD_LO;
    // forward order: 6 2 3 1 5 4
    unique case (hall_e'(hall_i))
      HALL_1: begin
        dec_o.drive_a = DRIVE_HIGH;
        dec_o.drive_c = DRIVE_LOW;
        up_from = HALL_3;
        dn_from = HALL_5;
      end
      HALL_2: begin
        dec_o.drive_b = DRIVE_LOW;
        dec_o.drive_c = DRIVE_HIGH;
        up_from = HALL_6;
        dn_from = HALL_3;
      end
      HALL_3: begin
        dec_o.drive_a = DRIVE_HIGH;
        dec_o.drive_b = DRIVE_LOW;
        up_from = HALL_2;
        dn_from = HALL_1;
      end
      HALL_4: begin
        dec_o.drive_a = DRIVE_LOW;
        dec_o.drive_b = DRIVE_HIGH;
        up_from = HALL_5;
        dn_from = HALL_6;
      end
      HALL_5: begin
        dec_o.drive_b = DRIVE_HIGH;
        dec_o.drive_c = DRIVE_LOW;
        up_from = HALL_1;
        dn_from = HALL_4;
      end
      HALL_6: begin
        dec_o.drive_a = DRIVE_LOW;
        dec_o.drive_c = DRIVE_HIGH;
        up_from = HALL_4;
        dn_from = HALL_2;
      end
      default: begin
        dec_o.fault = 1'b1;
      end
    endcase
    // up_from/dn_from stay at an invalid code on fault, prev can still be 0
    dec_o.step_up = !dec_o.fault && (prev_hall_i == up_from);
    dec_o.step_dn = !dec_o.fault && (prev_hall_i == dn_from);
  end

endmodule

FILE: rtl/bldc_hall_commutation.sv
// Six-step Hall commutation for a BLDC motor, top level.
// Result path: input register, then result register.
// Throughput: one item per cycle while out_stall_i does not hold a full result register; the path
// is one clamp, one 14x25 constant reciprocal multiply and one 12-bit add between the two registers.
// Reset: all phase levels 2048, count 0, previous Hall code 0, both registers empty.
// Depends on bhc_pkg, bhc_duty_scale, bhc_hall_decode.
module bldc_hall_commutation #(
  parameter int unsigned COUNT_WIDTH = bhc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [bhc_pkg::DUTY_W-1:0]  duty_command_i,
  input  logic        [bhc_pkg::HALL_W-1:0]  hall_code_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic        [bhc_pkg::LEVEL_W-1:0] phase_a_level_o,
  output logic        [bhc_pkg::LEVEL_W-1:0] phase_b_level_o,
  output logic        [bhc_pkg::LEVEL_W-1:0] phase_c_level_o,
  output logic signed [bhc_pkg::POS_W-1:0]   position_count_o,
  output logic signed [bhc_pkg::CLAMP_W-1:0] duty_applied_o,
  output logic                               hall_fault_o
);
  import bhc_pkg::*;

  // input register
  logic                      in_vld_q;
  logic signed [DUTY_W-1:0]  duty_q;
  logic        [HALL_W-1:0]  hall_q;

  // result register; levels, count and prev hall double as block state
  logic                       out_vld_q;
  logic        [LEVEL_W-1:0]  lvl_a_q, lvl_b_q, lvl_c_q;
  logic        [LEVEL_W-1:0]  lvl_a_d, lvl_b_d, lvl_c_d;
  logic        [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic        [HALL_W-1:0]   prev_hall_q;
  logic signed [CLAMP_W-1:0]  duty_app_q;
  logic                       fault_q;

  logic                       advance;
  logic signed [CLAMP_W-1:0]  duty_clamped;
  logic        [LEVEL_W-1:0]  level_hi, level_lo;
  hall_dec_t                  dec;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  bhc_duty_scale u_scale (
    .duty_i        (duty_q),
    .duty_clamped_o(duty_clamped),
    .level_hi_o    (level_hi),
    .level_lo_o    (level_lo)
  );

  bhc_hall_decode u_decode (
    .hall_i     (hall_q),
    .prev_hall_i(prev_hall_q),
    .dec_o      (dec)
  );

  function automatic logic [LEVEL_W-1:0] pick_level(drive_e drv, logic [LEVEL_W-1:0] hi,
                                                    logic [LEVEL_W-1:0] lo);
    logic [LEVEL_W-1:0] lvl;
    case (drv)
      DRIVE_HIGH: lvl = hi;
      DRIVE_LOW:  lvl = lo;
      default:    lvl = CENTER_LEVEL;
    endcase
    return lvl;
  endfunction

  always_comb begin
    lvl_a_d = lvl_a_q;
    lvl_b_d = lvl_b_q;
    lvl_c_d = lvl_c_q;
    cnt_d   = cnt_q;
    if (!dec.fault) begin
      lvl_a_d = pick_level(dec.drive_a, level_hi, level_lo);
      lvl_b_d = pick_level(dec.drive_b, level_hi, level_lo);
      lvl_c_d = pick_level(dec.drive_c, level_hi, level_lo);
    end
    if (dec.step_up) begin
      cnt_d = cnt_q + COUNT_WIDTH'(1);
    end else if (dec.step_dn) begin
      cnt_d = cnt_q - COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      duty_q <= duty_command_i;
      hall_q <= hall_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      lvl_a_q     <= CENTER_LEVEL;
      lvl_b_q     <= CENTER_LEVEL;
      lvl_c_q     <= CENTER_LEVEL;
      cnt_q       <= '0;
      prev_hall_q <= HALL_BAD_LO;
    end else begin
      if (advance) begin
        out_vld_q   <= 1'b1;
        lvl_a_q     <= lvl_a_d;
        lvl_b_q     <= lvl_b_d;
        lvl_c_q     <= lvl_c_d;
        cnt_q       <= cnt_d;
        prev_hall_q <= hall_q;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      duty_app_q <= duty_clamped;
      fault_q    <= dec.fault;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign phase_a_level_o  = lvl_a_q;
  assign phase_b_level_o  = lvl_b_q;
  assign phase_c_level_o  = lvl_c_q;
  assign position_count_o = POS_W'($signed(cnt_q));
  assign duty_applied_o   = duty_app_q;
  assign hall_fault_o     = fault_q;

  // fault item leaves the phase levels and the count as they were
  a_fault_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && dec.fault |=> $stable(lvl_a_q) && $stable(lvl_b_q) && $stable(lvl_c_q)
                             && $stable(cnt_q))
    else $error("fault item changed held levels or count");

  // count moves by at most one step per item
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + COUNT_WIDTH'(1))
                || (cnt_q == $past(cnt_q) - COUNT_WIDTH'(1)))
    else $error("position count jumped by more than one");

  // a good Hall code always leaves one phase floating at center
  a_one_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !fault_q |-> (lvl_a_q == CENTER_LEVEL) || (lvl_b_q == CENTER_LEVEL)
                              || (lvl_c_q == CENTER_LEVEL))
    else $error("no phase at center level for a valid Hall code");

  // input side only stalls while holding an item
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q)
    else $error("input stalled with room in the pipeline");

endmodule

FILE: tb/bhc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Hall commutation block: predicts each result from the
// accepted input items and compares it field by field. Depends on bhc_pkg.
module bhc_checker #(
  parameter int unsigned COUNT_WIDTH = bhc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic signed [bhc_pkg::DUTY_W-1:0]  duty_command_i,
  input  logic        [bhc_pkg::HALL_W-1:0]  hall_code_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic        [bhc_pkg::LEVEL_W-1:0] phase_a_level_i,
  input  logic        [bhc_pkg::LEVEL_W-1:0] phase_b_level_i,
  input  logic        [bhc_pkg::LEVEL_W-1:0] phase_c_level_i,
  input  logic signed [bhc_pkg::POS_W-1:0]   position_count_i,
  input  logic signed [bhc_pkg::CLAMP_W-1:0] duty_applied_i,
  input  logic                               hall_fault_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o,
  output int unsigned                        checked_o,
  output int unsigned                        faults_o,
  output int unsigned                        steps_up_o,
  output int unsigned                        steps_down_o
);
  import bhc_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_a;
    logic [LEVEL_W-1:0] level_b;
    logic [LEVEL_W-1:0] level_c;
    logic [POS_W-1:0]   count;
    logic [CLAMP_W-1:0] duty;
    logic               fault;
  } tick_result_t;

  tick_result_t           expected_q[$];
  tick_result_t           want;
  tick_result_t           got_next;
  hall_e                  last_hall;
  logic [COUNT_WIDTH-1:0] hall_steps;
  logic [LEVEL_W-1:0]     held_level[3];

  // forward rotation: 6 2 3 1 5 4 6
  function automatic hall_e forward_of(hall_e h);
    case (h)
      HALL_6:  return HALL_2;
      HALL_2:  return HALL_3;
      HALL_3:  return HALL_1;
      HALL_1:  return HALL_5;
      HALL_5:  return HALL_4;
      HALL_4:  return HALL_6;
      default: return HALL_BAD_LO;
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] drive_level(drive_e dr, int offset);
    case (dr)
      DRIVE_HIGH: return 12'(2048 + offset);
      DRIVE_LOW:  return 12'(2048 - offset);
      default:    return CENTER_LEVEL;
    endcase
  endfunction

  task automatic commutate(input logic signed [DUTY_W-1:0] cmd, input hall_e h,
                           output tick_result_t res);
    int     duty;
    int     offset;
    drive_e da;
    drive_e db;
    drive_e dc;
    logic   fault;
    duty = cmd;
    if (duty > DUTY_LIMIT) duty = DUTY_LIMIT;
    else if (duty < -DUTY_LIMIT) duty = -DUTY_LIMIT;
    // int division truncates toward zero, as required
    offset = (duty * 2047) / DUTY_LIMIT;
    fault = (h == HALL_BAD_LO) || (h == HALL_BAD_HI);
    da = DRIVE_CENTER;
    db = DRIVE_CENTER;
    dc = DRIVE_CENTER;
    case (h)
      HALL_1: begin da = DRIVE_HIGH; dc = DRIVE_LOW;  end
      HALL_2: begin db = DRIVE_LOW;  dc = DRIVE_HIGH; end
      HALL_3: begin da = DRIVE_HIGH; db = DRIVE_LOW;  end
      HALL_4: begin da = DRIVE_LOW;  db = DRIVE_HIGH; end
      HALL_5: begin db = DRIVE_HIGH; dc = DRIVE_LOW;  end
      HALL_6: begin da = DRIVE_LOW;  dc = DRIVE_HIGH; end
      default: ;
    endcase
    if (!fault) begin
      held_level[0] = drive_level(da, offset);
      held_level[1] = drive_level(db, offset);
      held_level[2] = drive_level(dc, offset);
      // an invalid previous code never matches either direction
      if (h == forward_of(last_hall)) begin
        hall_steps = hall_steps + 1'b1;
        steps_up_o++;
      end else if (forward_of(h) == last_hall) begin
        hall_steps = hall_steps - 1'b1;
        steps_down_o++;
      end
    end else begin
      faults_o++;
    end
    last_hall     = h;
    res.level_a   = held_level[0];
    res.level_b   = held_level[1];
    res.level_c   = held_level[2];
    res.count     = 32'($signed(hall_steps));
    res.duty      = 15'(duty);
    res.fault     = fault;
  endtask

  task automatic check_field(input string field, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      last_hall     = HALL_BAD_LO;
      hall_steps    = '0;
      held_level[0] = CENTER_LEVEL;
      held_level[1] = CENTER_LEVEL;
      held_level[2] = CENTER_LEVEL;
      pending_o     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no item pending, count %0d", $time, position_count_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("phase_a_level", want.level_a, phase_a_level_i);
          check_field("phase_b_level", want.level_b, phase_b_level_i);
          check_field("phase_c_level", want.level_c, phase_c_level_i);
          check_field("position_count", $signed(want.count), position_count_i);
          check_field("duty_applied", $signed(want.duty), duty_applied_i);
          check_field("hall_fault", want.fault, hall_fault_i);
          checked_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        commutate(duty_command_i, hall_e'(hall_code_i), got_next);
        expected_q.push_back(got_next);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

FILE: tb/tb_bldc_hall_commutation.sv
`timescale 1ns / 1ps
// Testbench top for bldc_hall_commutation: drives directed and random
// commutation ticks with bursty input and stalling output. Uses bhc_checker.
module tb_bldc_hall_commutation;
  import bhc_pkg::*;

  localparam int N_RANDOM       = 1300;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_stall_o;
  logic signed [DUTY_W-1:0]  duty_command_i = '0;
  logic        [HALL_W-1:0]  hall_code_i    = '0;
  logic                      out_valid_o;
  logic                      out_stall_i    = 1'b0;
  logic        [LEVEL_W-1:0] phase_a_level_o;
  logic        [LEVEL_W-1:0] phase_b_level_o;
  logic        [LEVEL_W-1:0] phase_c_level_o;
  logic signed [POS_W-1:0]   position_count_o;
  logic signed [CLAMP_W-1:0] duty_applied_o;
  logic                      hall_fault_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned faults;
  int unsigned steps_up;
  int unsigned steps_down;

  int          burst_left = 0;
  int unsigned sent_items = 0;

  always #2 clk_i = ~clk_i;

  bldc_hall_commutation i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .duty_command_i   (duty_command_i),
    .hall_code_i      (hall_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .phase_a_level_o  (phase_a_level_o),
    .phase_b_level_o  (phase_b_level_o),
    .phase_c_level_o  (phase_c_level_o),
    .position_count_o (position_count_o),
    .duty_applied_o   (duty_applied_o),
    .hall_fault_o     (hall_fault_o)
  );

  bhc_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .duty_command_i   (duty_command_i),
    .hall_code_i      (hall_code_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .phase_a_level_i  (phase_a_level_o),
    .phase_b_level_i  (phase_b_level_o),
    .phase_c_level_i  (phase_c_level_o),
    .position_count_i (position_count_o),
    .duty_applied_i   (duty_applied_o),
    .hall_fault_i     (hall_fault_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .faults_o         (faults),
    .steps_up_o       (steps_up),
    .steps_down_o     (steps_down)
  );

  // offer one item; bursts of random length with random gaps in between
  task automatic offer(input logic signed [DUTY_W-1:0] duty, input hall_e hall);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 50);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    duty_command_i <= duty;
    hall_code_i    <= hall;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic hall_e hall_step(hall_e h, bit fwd);
    case (h)
      HALL_6:  return fwd ? HALL_2 : HALL_4;
      HALL_2:  return fwd ? HALL_3 : HALL_6;
      HALL_3:  return fwd ? HALL_1 : HALL_2;
      HALL_1:  return fwd ? HALL_5 : HALL_3;
      HALL_5:  return fwd ? HALL_4 : HALL_1;
      HALL_4:  return fwd ? HALL_6 : HALL_5;
      default: return hall_e'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic signed [DUTY_W-1:0] rand_duty();
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 45) v = int'($urandom_range(0, 20000)) - 10000;
    else if (pick < 70) v = $urandom_range(0, 65535);
    else if (pick < 85) v = ($urandom_range(0, 1) ? 10000 : -10000) +
                            int'($urandom_range(0, 6)) - 3;
    else v = int'($urandom_range(0, 40)) - 20;
    return 16'(v);
  endfunction

  // receiver: free-running stretches, random stalls, a fixed pattern,
  // and one long hold-off so the pipeline backs up into in_stall_o
  initial begin
    int seg;
    int len;
    int mode;
    seg = 0;
    forever begin
      mode = (seg == 4) ? 3 : $urandom_range(0, 2);
      len  = (mode == 3) ? HOLD_CYCLES : $urandom_range(10, 60);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 99) < 40);
          2:       out_stall_i <= (i % 4 != 0);
          default: out_stall_i <= 1'b1;
        endcase
        @(posedge clk_i);
      end
      seg++;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    hall_e cur_hall;
    int    pick;
    bit    up_bias;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first tick after reset, a full forward turn with duty extremes,
    // then backward steps, faults and out-of-order codes
    offer(0, HALL_1);
    offer(32767, HALL_5);
    offer(-32768, HALL_4);
    offer(10000, HALL_6);
    offer(-10000, HALL_2);
    offer(10001, HALL_3);
    offer(-10001, HALL_1);
    offer(1, HALL_1);
    offer(-1, HALL_3);
    offer(5, HALL_2);
    offer(-5, HALL_6);
    offer(9999, HALL_4);
    offer(-9999, HALL_BAD_HI);
    offer(123, HALL_5);
    offer(-123, HALL_BAD_LO);
    offer(0, HALL_BAD_LO);
    offer(16384, HALL_4);
    offer(-16385, HALL_1);
    offer(32767, HALL_BAD_HI);
    offer(-32768, HALL_2);
    offer(2, HALL_5);

    cur_hall = HALL_5;
    up_bias  = 1'b1;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) drain();
      if (n % 100 == 0) up_bias = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (pick < 75) cur_hall = hall_step(cur_hall, up_bias ? (pick < 55) : (pick >= 55));
      else if (pick < 85) ;
      else if (pick < 93) cur_hall = $urandom_range(0, 1) ? HALL_BAD_HI : HALL_BAD_LO;
      else cur_hall = hall_e'($urandom_range(0, 7));
      offer(rand_duty(), cur_hall);
    end

    drain();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d ticks, checked %0d results: %0d Hall faults,", sent_items, checked,
             faults);
    $display("%0d forward and %0d backward steps, final count %0d", steps_up, steps_down,
             position_count_o);
    if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
